### hdl/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg: shared types and constants
// Types, codes and widths used by the max-heap priority queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int KEY_W        = 32;
    localparam int STATUS_W     = 2;
    localparam int FILL_W       = 8;

    typedef enum logic [0:0] {
        CMD_INSERT  = 1'b0,
        CMD_EXTRACT = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_DN_LAST,
        S_DN_CHK,
        S_DN_L,
        S_DN_R,
        S_DONE
    } state_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        status_t                 status;
        logic [FILL_W-1:0]       fill;
    } result_t;

endpackage

`default_nettype wire

### hdl/mhpq_ram.sv
// ----------------------------------------------------------------------------
// mhpq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hdl/mhpq_seq.sv
// ----------------------------------------------------------------------------
// mhpq_seq: heap sequencer
// Walks sift-up and sift-down one level at a time around one shared signed
// comparator and the key store RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_seq #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire mhpq_pkg::cmd_t                     start_cmd,
    input  wire logic signed [mhpq_pkg::KEY_W-1:0]  start_key,
    output logic                                    busy,
    output logic                                    res_valid,
    output mhpq_pkg::result_t                       res,
    input  wire logic                               res_ack,
    output logic                                    ram_we,
    output logic [AW-1:0]                           ram_waddr,
    output logic signed [mhpq_pkg::KEY_W-1:0]       ram_wdata,
    output logic [AW-1:0]                           ram_raddr,
    input  wire logic signed [mhpq_pkg::KEY_W-1:0]  ram_rdata
);

    mhpq_pkg::state_t  state_reg, state_next;
    mhpq_pkg::status_t status_reg, status_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] best_reg, best_next;
    logic signed [mhpq_pkg::KEY_W-1:0] key_reg, key_next;
    logic signed [mhpq_pkg::KEY_W-1:0] bestval_reg, bestval_next;
    logic signed [mhpq_pkg::KEY_W-1:0] root_reg, root_next;
    logic signed [mhpq_pkg::KEY_W-1:0] res_key_reg, res_key_next;
    logic res_root_reg, res_root_next;

    logic signed [mhpq_pkg::KEY_W-1:0] cmp_a, cmp_b;
    logic          cmp_gt;
    logic [CW-1:0] pos_m1;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] parent;
    logic [CW-1:0] parent_m1;
    logic [CW:0]   l_ext;
    logic [CW:0]   l_m1;
    logic [CW:0]   r_ext;
    logic [CW:0]   cnt_ext;
    logic [CW+mhpq_pkg::FILL_W-1:0] fill_ext;

    assign pos_m1    = pos_reg - CW'(1);
    assign cnt_m1    = count_reg - CW'(1);
    assign parent    = pos_reg >> 1;
    assign parent_m1 = parent - CW'(1);
    assign l_ext     = {pos_reg, 1'b0};
    assign l_m1      = {pos_m1, 1'b1};
    assign r_ext     = {pos_reg, 1'b1};
    assign cnt_ext   = {1'b0, count_reg};
    assign fill_ext  = {{mhpq_pkg::FILL_W{1'b0}}, count_reg};

    // shared comparator
    always_comb
    begin
        unique case (state_reg)
            mhpq_pkg::S_DN_L:
            begin
                cmp_a = ram_rdata;
                cmp_b = key_reg;
            end
            mhpq_pkg::S_DN_R:
            begin
                cmp_a = ram_rdata;
                cmp_b = bestval_reg;
            end
            default:
            begin
                cmp_a = key_reg;
                cmp_b = ram_rdata;
            end
        endcase
    end

    assign cmp_gt = cmp_a > cmp_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mhpq_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        pos_reg      <= pos_next;
        best_reg     <= best_next;
        key_reg      <= key_next;
        bestval_reg  <= bestval_next;
        root_reg     <= root_next;
        res_key_reg  <= res_key_next;
        res_root_reg <= res_root_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        status_next   = status_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        best_next     = best_reg;
        key_next      = key_reg;
        bestval_next  = bestval_reg;
        res_key_next  = res_key_reg;
        res_root_next = res_root_reg;
        ram_we        = 1'b0;
        ram_waddr     = pos_m1[AW-1:0];
        ram_wdata     = key_reg;
        ram_raddr     = '0;

        unique case (state_reg)
            mhpq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    key_next    = start_key;
                    status_next = mhpq_pkg::ST_OK;
                    if (start_cmd == mhpq_pkg::CMD_INSERT)
                    begin
                        res_root_next = 1'b1;
                        if (count_reg == CW'(CAPACITY))
                        begin
                            status_next = mhpq_pkg::ST_FULL;
                            state_next  = mhpq_pkg::S_DONE;
                        end
                        else
                        begin
                            count_next = count_reg + CW'(1);
                            pos_next   = count_reg + CW'(1);
                            state_next = mhpq_pkg::S_UP_CHK;
                        end
                    end
                    else
                    begin
                        res_root_next = 1'b0;
                        res_key_next  = root_reg;
                        if (count_reg == '0)
                        begin
                            status_next  = mhpq_pkg::ST_EMPTY;
                            res_key_next = '0;
                            state_next   = mhpq_pkg::S_DONE;
                        end
                        else
                        begin
                            count_next = cnt_m1;
                            ram_raddr  = cnt_m1[AW-1:0];
                            if (count_reg == CW'(1))
                            begin
                                state_next = mhpq_pkg::S_DONE;
                            end
                            else
                            begin
                                state_next = mhpq_pkg::S_DN_LAST;
                            end
                        end
                    end
                end
            end
            mhpq_pkg::S_UP_CHK:
            begin
                if (pos_reg == CW'(1))
                begin
                    ram_we     = 1'b1;
                    state_next = mhpq_pkg::S_DONE;
                end
                else
                begin
                    ram_raddr  = parent_m1[AW-1:0];
                    state_next = mhpq_pkg::S_UP_CMP;
                end
            end
            mhpq_pkg::S_UP_CMP:
            begin
                ram_we = 1'b1;
                if (cmp_gt)
                begin
                    ram_wdata  = ram_rdata;
                    pos_next   = parent;
                    state_next = mhpq_pkg::S_UP_CHK;
                end
                else
                begin
                    state_next = mhpq_pkg::S_DONE;
                end
            end
            mhpq_pkg::S_DN_LAST:
            begin
                key_next   = ram_rdata;
                pos_next   = CW'(1);
                state_next = mhpq_pkg::S_DN_CHK;
            end
            mhpq_pkg::S_DN_CHK:
            begin
                if (l_ext > cnt_ext)
                begin
                    ram_we     = 1'b1;
                    state_next = mhpq_pkg::S_DONE;
                end
                else
                begin
                    ram_raddr  = l_m1[AW-1:0];
                    state_next = mhpq_pkg::S_DN_L;
                end
            end
            mhpq_pkg::S_DN_L:
            begin
                bestval_next = cmp_gt ? ram_rdata : key_reg;
                best_next    = cmp_gt ? l_ext[CW-1:0] : pos_reg;
                if (r_ext <= cnt_ext)
                begin
                    ram_raddr  = l_ext[AW-1:0];
                    state_next = mhpq_pkg::S_DN_R;
                end
                else
                begin
                    ram_we = 1'b1;
                    if (cmp_gt)
                    begin
                        ram_wdata  = ram_rdata;
                        pos_next   = l_ext[CW-1:0];
                        state_next = mhpq_pkg::S_DN_CHK;
                    end
                    else
                    begin
                        state_next = mhpq_pkg::S_DONE;
                    end
                end
            end
            mhpq_pkg::S_DN_R:
            begin
                ram_we = 1'b1;
                if (cmp_gt)
                begin
                    ram_wdata  = ram_rdata;
                    pos_next   = r_ext[CW-1:0];
                    state_next = mhpq_pkg::S_DN_CHK;
                end
                else if (best_reg != pos_reg)
                begin
                    ram_wdata  = bestval_reg;
                    pos_next   = best_reg;
                    state_next = mhpq_pkg::S_DN_CHK;
                end
                else
                begin
                    state_next = mhpq_pkg::S_DONE;
                end
            end
            mhpq_pkg::S_DONE:
            begin
                if (res_ack)
                begin
                    state_next = mhpq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mhpq_pkg::S_IDLE;
            end
        endcase
    end

    // shadow of the root slot
    assign root_next = (ram_we && ram_waddr == '0) ? ram_wdata : root_reg;

    assign busy       = state_reg != mhpq_pkg::S_IDLE;
    assign res_valid  = state_reg == mhpq_pkg::S_DONE;
    assign res.key    = res_root_reg ? root_reg : res_key_reg;
    assign res.status = status_reg;
    assign res.fill   = fill_ext[mhpq_pkg::FILL_W-1:0];

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == mhpq_pkg::S_UP_CHK || state_reg == mhpq_pkg::S_UP_CMP
                    || state_reg == mhpq_pkg::S_DN_CHK || state_reg == mhpq_pkg::S_DN_L
                    || state_reg == mhpq_pkg::S_DN_R))
        else $error("store written outside a sift");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status == mhpq_pkg::ST_EMPTY) |-> count_reg == '0)
        else $error("empty status with keys held");

    a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start work");

endmodule

`default_nettype wire

### hdl/max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue: binary max-heap of signed 32-bit keys
// Insert or extract-max on a heap held in a RAM, one result per item.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall) carries cmd and key_in: insert
//   key_in, or extract the maximum. Response channel (rsp_valid/rsp_stall)
//   returns key_out, status and fill_count for every request, in order.
//   The time from accept to rsp_valid is set by the sift walk through the
//   registered-read key store and the one shared comparator: an insert
//   raises the key one level per step until it stops below a larger
//   parent or reaches the root, an extract sinks the last entry from the
//   root one level per step, and full/empty refusals and extract of the
//   last key go straight to the result. One item is in work at a time;
//   req_stall is high while it runs, and the next item is accepted in the
//   cycle after the result moves to the response register. A finished
//   item holds while the response register waits on rsp_stall.
//   Reset empties the heap at once; store contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module max_heap_priority_queue #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   req_valid,
    output logic                                        req_stall,
    input  wire logic                                   cmd,
    input  wire logic signed [mhpq_pkg::KEY_W-1:0]      key_in,
    output logic                                        rsp_valid,
    input  wire logic                                   rsp_stall,
    output logic signed [mhpq_pkg::KEY_W-1:0]           key_out,
    output logic [mhpq_pkg::STATUS_W-1:0]               status,
    output logic [mhpq_pkg::FILL_W-1:0]                 fill_count
);

    localparam int AW = $clog2(CAPACITY);

    logic              busy;
    logic              start;
    logic              res_valid;
    logic              load;
    mhpq_pkg::result_t res;
    mhpq_pkg::result_t out_reg;
    logic              valid_reg, valid_next;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic signed [mhpq_pkg::KEY_W-1:0] ram_wdata;
    logic signed [mhpq_pkg::KEY_W-1:0] ram_rdata;

    assign req_stall = busy;
    assign start     = req_valid && !busy;
    assign load      = res_valid && (!valid_reg || !rsp_stall);
    assign valid_next = load || (valid_reg && rsp_stall);

    mhpq_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .start_cmd (mhpq_pkg::cmd_t'(cmd)),
        .start_key (key_in),
        .busy      (busy),
        .res_valid (res_valid),
        .res       (res),
        .res_ack   (load),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    mhpq_ram #(
        .WIDTH (mhpq_pkg::KEY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= res;
        end
    end

    assign rsp_valid  = valid_reg;
    assign key_out    = out_reg.key;
    assign status     = out_reg.status;
    assign fill_count = out_reg.fill;

endmodule

`default_nettype wire
